// ===== hdl/rsd_pkg.sv =====
`default_nettype none
package rsd_pkg;
	localparam logic [1:0] OP_LOAD_FREQ  = 2'd0;
	localparam logic [1:0] OP_LOAD_STATE = 2'd1;
	localparam logic [1:0] OP_DECODE     = 2'd2;
	localparam logic [1:0] CFG_CHUNK  = 2'd0;
	localparam logic [1:0] CFG_NORM   = 2'd1;
	localparam logic [1:0] CFG_SYMCNT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_DIV, ST_SEARCH, ST_MUL, ST_RENORM, ST_OUT
	} rsd_state_t;

	typedef struct packed {
		logic load_item;   // capture input, perform loads
		logic start_check;
		logic div_step;
		logic srch_step;
		logic mul_step;
		logic renorm_step;
	} rsd_cmd_t;

	typedef struct packed {
		logic is_decode;
		logic refuse;      // range check failed
		logic div_done;
		logic srch_done;
		logic srch_miss;
		logic renorm_done;
	} rsd_status_t;
endpackage
`default_nettype wire

// ===== hdl/rsd_ctrl.sv =====
`default_nettype none
module rsd_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  wire logic out_stall,
	input  wire rsd_pkg::rsd_status_t sts,
	output rsd_pkg::rsd_cmd_t cmd
);
	rsd_pkg::rsd_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rsd_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rsd_pkg::ST_IDLE: if (in_valid) state_d = rsd_pkg::ST_CHECK;
			rsd_pkg::ST_CHECK: begin
				if (!sts.is_decode) state_d = rsd_pkg::ST_IDLE;
				else if (sts.refuse) state_d = rsd_pkg::ST_OUT;
				else state_d = rsd_pkg::ST_DIV;
			end
			rsd_pkg::ST_DIV: if (sts.div_done) state_d = rsd_pkg::ST_SEARCH;
			rsd_pkg::ST_SEARCH: begin
				if (sts.srch_done) state_d = sts.srch_miss ? rsd_pkg::ST_OUT : rsd_pkg::ST_MUL;
			end
			rsd_pkg::ST_MUL: state_d = rsd_pkg::ST_RENORM;
			rsd_pkg::ST_RENORM: if (sts.renorm_done) state_d = rsd_pkg::ST_OUT;
			rsd_pkg::ST_OUT: if (!out_stall) state_d = rsd_pkg::ST_IDLE;
			default: state_d = rsd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			rsd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load_item = in_valid;
			end
			rsd_pkg::ST_CHECK: cmd.start_check = 1'b1;
			rsd_pkg::ST_DIV: cmd.div_step = 1'b1;
			rsd_pkg::ST_SEARCH: cmd.srch_step = 1'b1;
			rsd_pkg::ST_MUL: cmd.mul_step = 1'b1;
			rsd_pkg::ST_RENORM: cmd.renorm_step = 1'b1;
			rsd_pkg::ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken during result");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rsd_pkg::ST_MUL) |=> (state_q == rsd_pkg::ST_RENORM))
		else $error("multiply not followed by renorm");
endmodule
`default_nettype wire

// ===== hdl/rsd_datapath.sv =====
`default_nettype none
module rsd_datapath #(
	parameter int ALPHABET  = 256,
	parameter int FREQ_BITS = 17
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  entry_index,
	input  wire logic [31:0] load_value,
	input  wire logic [31:0] bit_window,
	input  wire logic        cfg_valid,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire rsd_pkg::rsd_cmd_t cmd,
	output rsd_pkg::rsd_status_t sts,
	output logic [7:0]       symbol,
	output logic [5:0]       bits_used,
	output logic [31:0]      state_after,
	output logic             range_error
);
	localparam int AW = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int CW = AW + 1;
	localparam logic [FREQ_BITS-1:0] FMAX = {FREQ_BITS{1'b1}};

	logic [FREQ_BITS-1:0] freq_mem [ALPHABET];
	logic [FREQ_BITS-1:0] cum_mem  [ALPHABET];
	logic [FREQ_BITS-1:0] total_q;
	logic [31:0] coder_q;
	logic [4:0]  chunk_q, norm_q;
	logic [8:0]  symcnt_q;
	logic [1:0]  op_q;
	logic [31:0] win_q;

	// effective configuration
	logic [4:0] lb, kl;
	logic [CW-1:0] n_eff;
	assign lb = (chunk_q == 5'd0) ? 5'd1 : ((chunk_q > 5'd16) ? 5'd16 : chunk_q);
	assign kl = (norm_q > 5'd16) ? 5'd16 : norm_q;
	always_comb begin
		if ({{(CW > 9 ? CW-9 : 0){1'b0}}, symcnt_q} > ALPHABET) n_eff = CW'(ALPHABET);
		else n_eff = CW'(symcnt_q);
	end

	logic [63:0] lo, hi;
	assign lo = {{(64-FREQ_BITS){1'b0}}, total_q} << kl;
	assign hi = lo << lb;

	// frequency load with saturation
	logic [FREQ_BITS-1:0] f_sat, base;
	logic [FREQ_BITS:0] sum;
	assign f_sat = (load_value > 32'(FMAX)) ? FMAX : FREQ_BITS'(load_value);
	assign base = (entry_index == 8'd0) ? '0 : total_q;
	assign sum = {1'b0, base} + {1'b0, f_sat};
	logic idx_ok;
	assign idx_ok = {{(AW > 8 ? AW-8 : 0){1'b0}}, entry_index} < ALPHABET;

	always_ff @(posedge clk) begin
		if (cmd.load_item && op == rsd_pkg::OP_LOAD_FREQ && idx_ok) begin
			freq_mem[AW'(entry_index)] <= f_sat;
			cum_mem[AW'(entry_index)] <= base;
		end
	end

	// divider: restoring, one bit per cycle
	logic [31:0] quo_q;
	logic [FREQ_BITS-1:0] rem_q;
	logic [4:0] dcnt_q;
	logic [FREQ_BITS:0] trial;
	assign trial = {rem_q, quo_q[31]};

	// linear search over the table, one entry a cycle, memory read registered
	logic [CW-1:0] sidx_q;
	logic [AW-1:0] rd_addr;
	logic [FREQ_BITS-1:0] rf_q, rc_q;
	logic rvalid_q;
	logic [AW-1:0] ridx_q;
	logic [AW-1:0] sym_q;
	logic [FREQ_BITS-1:0] fs_q, cs_q;
	assign rd_addr = sidx_q[AW-1:0];
	always_ff @(posedge clk) begin
		rf_q <= freq_mem[rd_addr];
		rc_q <= cum_mem[rd_addr];
	end
	logic hit;
	assign hit = rvalid_q && (rf_q != '0) && (rc_q <= rem_q)
		&& ({1'b0, rem_q} < ({1'b0, rc_q} + {1'b0, rf_q}));

	logic [31+FREQ_BITS:0] prod;
	assign prod = quo_q * fs_q;
	logic [31:0] s_q;
	logic [5:0] used_q;
	logic [31:0] chunk;
	assign chunk = (win_q << used_q) >> (6'd32 - {1'b0, lb});
	logic rn_go;
	assign rn_go = ({32'd0, s_q} < lo) && ({1'b0, used_q} + {2'b0, lb} <= 7'd32);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0; coder_q <= '0; chunk_q <= 5'd8; norm_q <= 5'd0; symcnt_q <= 9'd256;
			op_q <= '0; dcnt_q <= '0; sidx_q <= '0; rvalid_q <= 1'b0;
			range_error <= 1'b0; used_q <= '0; win_q <= '0; quo_q <= '0; rem_q <= '0;
			ridx_q <= '0; sym_q <= '0; fs_q <= '0; cs_q <= '0; s_q <= '0;
			symbol <= '0; bits_used <= '0; state_after <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					rsd_pkg::CFG_CHUNK:  chunk_q <= cfg_data[4:0];
					rsd_pkg::CFG_NORM:   norm_q <= cfg_data[4:0];
					rsd_pkg::CFG_SYMCNT: symcnt_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (cmd.load_item) begin
				op_q <= op;
				win_q <= bit_window;
				if (op == rsd_pkg::OP_LOAD_FREQ && idx_ok)
					total_q <= sum[FREQ_BITS] ? FMAX : sum[FREQ_BITS-1:0];
				if (op == rsd_pkg::OP_LOAD_STATE) coder_q <= load_value;
			end
			if (cmd.start_check) begin
				quo_q <= coder_q; rem_q <= '0; dcnt_q <= '0;
				range_error <= 1'b1; symbol <= '0; bits_used <= '0; state_after <= coder_q;
				sidx_q <= '0; rvalid_q <= 1'b0;
			end
			if (cmd.div_step) begin
				if (trial >= {1'b0, total_q}) begin
					rem_q <= FREQ_BITS'(trial - {1'b0, total_q});
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= trial[FREQ_BITS-1:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
				dcnt_q <= dcnt_q + 5'd1;
			end
			if (cmd.srch_step) begin
				rvalid_q <= sidx_q < n_eff;
				ridx_q <= rd_addr;
				sidx_q <= sidx_q + CW'(1);
				if (hit) begin
					sym_q <= ridx_q; fs_q <= rf_q; cs_q <= rc_q;
				end
			end
			if (cmd.mul_step) begin
				s_q <= prod[31:0] + {{(32-FREQ_BITS){1'b0}}, rem_q}
					- {{(32-FREQ_BITS){1'b0}}, cs_q};
				used_q <= '0;
			end
			if (cmd.renorm_step) begin
				if (rn_go) begin
					s_q <= (s_q << lb) | chunk;
					used_q <= used_q + {1'b0, lb};
				end else begin
					symbol <= 8'(sym_q);
					bits_used <= used_q;
					state_after <= s_q;
					coder_q <= s_q;
					range_error <= 1'b0;
				end
			end
		end
	end

	assign sts.is_decode = (op_q == rsd_pkg::OP_DECODE);
	assign sts.refuse = (total_q == '0) || ({32'd0, coder_q} < lo) || ({32'd0, coder_q} >= hi);
	assign sts.div_done = (dcnt_q == 5'd31) && cmd.div_step;
	assign sts.srch_done = hit || (!rvalid_q && sidx_q > n_eff) || (sidx_q > n_eff + CW'(1));
	assign sts.srch_miss = !hit;
	assign sts.renorm_done = !rn_go;
endmodule
`default_nettype wire

// ===== hdl/rans_symbol_decoder.sv =====
`default_nettype none
// rANS symbol decoder, one item at a time; a load item returns to idle after the check state
// a decode result follows the 32-step divider, the one-entry-a-cycle table scan
// and the chunk loop; a symbol miss skips the chunk loop, a range refusal all three;
// the next item can be accepted in the cycle after the result transaction
// reset clears state, total and other registers but sets chunk 8 and symbol count 256;
// frequency tables hold nothing until loaded
module rans_symbol_decoder #(
	parameter int ALPHABET  = 256,
	parameter int FREQ_BITS = 17
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  op,
	input  wire logic [7:0]  entry_index,
	input  wire logic [31:0] load_value,
	input  wire logic [31:0] bit_window,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       symbol,
	output logic [5:0]       bits_used,
	output logic [31:0]      state_after,
	output logic             range_error,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	rsd_pkg::rsd_cmd_t cmd;
	rsd_pkg::rsd_status_t sts;
	assign cfg_ready = 1'b1;

	rsd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	rsd_datapath #(.ALPHABET(ALPHABET), .FREQ_BITS(FREQ_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .entry_index(entry_index),
		.load_value(load_value), .bit_window(bit_window),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.cmd(cmd), .sts(sts), .symbol(symbol), .bits_used(bits_used),
		.state_after(state_after), .range_error(range_error)
	);
endmodule
`default_nettype wire
